### design/vpr_pkg.sv
`timescale 1ns / 1ps

package vpr_pkg;

   // Coefficient format: signed, 16 fraction bits, range -1.0 .. +1.0
   localparam int COEF_W    = 18;
   localparam int COEF_FRAC = 16;
   localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd65536;

   // Coefficient slice handled by one cell of the multiply chain
   localparam int SLICE_W = 9;
   localparam int NCELL   = COEF_W / SLICE_W;

   // Angle handling
   localparam int ANGLE_W     = 16;
   localparam int DEG_W       = 9;
   localparam int SUM_W       = 17;
   localparam int IDX_W       = 7;
   localparam int TABLE_W     = 17;
   localparam int DEG_TURN    = 360;
   localparam int DEG_HALF    = 180;
   localparam int DEG_QUARTER = 90;
   localparam int DEG_THREEQ  = 270;
   // Whole turns added so that any 16-bit signed angle becomes non-negative
   localparam int DEG_OFFSET  = DEG_TURN * 92;
   localparam int REDUCE_STEPS = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = ANGLE_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_SELECT  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_DEGREES = 4'd1;

   localparam int PLANE_W = 2;
   typedef enum logic [PLANE_W-1:0] {
      PLANE_XY = 2'd0,
      PLANE_YZ = 2'd1,
      PLANE_ZX = 2'd2
   } plane_type;

   // round(sin(d deg) * 65536), d = 0 .. 90
   localparam logic [TABLE_W-1:0] QUARTER_SINE [0:90] = '{
      17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,
      17'd5712,  17'd6850,  17'd7987,  17'd9121,  17'd10252,
      17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
      17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336,
      17'd22415, 17'd23486, 17'd24550, 17'd25607, 17'd26656,
      17'd27697, 17'd28729, 17'd29753, 17'd30767, 17'd31772,
      17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
      17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243,
      17'd42126, 17'd42995, 17'd43852, 17'd44695, 17'd45525,
      17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
      17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020,
      17'd53684, 17'd54332, 17'd54963, 17'd55578, 17'd56175,
      17'd56756, 17'd57319, 17'd57865, 17'd58393, 17'd58903,
      17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
      17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997,
      17'd63303, 17'd63589, 17'd63856, 17'd64104, 17'd64332,
      17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
      17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526,
      17'd65536
   };

endpackage

### design/vpr_cell.sv
`timescale 1ns / 1ps

// One cell of the multiply chain: multiplies the pair by one coefficient slice
// and adds the weighted partial result onto the running sums from its neighbor.
module vpr_cell #(
   parameter int COORD_WIDTH = 32,
   parameter int ACC_WIDTH   = 51,
   parameter int SLICE_POS   = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                valid_in,
   input  logic signed [COORD_WIDTH-1:0]       a_in,
   input  logic signed [COORD_WIDTH-1:0]       b_in,
   input  logic signed [COORD_WIDTH-1:0]       t_in,
   input  logic signed [ACC_WIDTH-1:0]         acc_a_prev,
   input  logic signed [ACC_WIDTH-1:0]         acc_b_prev,
   input  logic [vpr_pkg::SLICE_W-1:0]         cos_slice,
   input  logic [vpr_pkg::SLICE_W-1:0]         sin_slice,
   output logic                                valid_out,
   output logic signed [COORD_WIDTH-1:0]       a_out,
   output logic signed [COORD_WIDTH-1:0]       b_out,
   output logic signed [COORD_WIDTH-1:0]       t_out,
   output logic signed [ACC_WIDTH-1:0]         acc_a_out,
   output logic signed [ACC_WIDTH-1:0]         acc_b_out
);
   import vpr_pkg::*;

   localparam int  SHIFT     = SLICE_POS * SLICE_W;
   localparam bit  TOP_SLICE = (SLICE_POS == NCELL - 1);
   localparam int  PROD_W    = COORD_WIDTH + SLICE_W + 1;
   localparam int  TERM_W    = PROD_W + 1;

   logic signed [SLICE_W:0]           cos_ext;
   logic signed [SLICE_W:0]           sin_ext;
   logic signed [PROD_W-1:0]          a_cos, b_sin, b_cos, a_sin;
   logic signed [TERM_W-1:0]          term_a, term_b;
   logic signed [ACC_WIDTH-1:0]       acc_a_in, acc_b_in;

   logic                              valid_ff;
   logic signed [COORD_WIDTH-1:0]     a_ff, b_ff, t_ff;
   logic signed [ACC_WIDTH-1:0]       acc_a_ff, acc_b_ff;

   // Only the top slice carries the coefficient sign
   assign cos_ext = TOP_SLICE ? {cos_slice[SLICE_W-1], cos_slice} : {1'b0, cos_slice};
   assign sin_ext = TOP_SLICE ? {sin_slice[SLICE_W-1], sin_slice} : {1'b0, sin_slice};

   assign a_cos = a_in * cos_ext;
   assign b_sin = b_in * sin_ext;
   assign b_cos = b_in * cos_ext;
   assign a_sin = a_in * sin_ext;

   assign term_a = TERM_W'(a_cos) - TERM_W'(b_sin);
   assign term_b = TERM_W'(b_cos) + TERM_W'(a_sin);

   assign acc_a_in = acc_a_prev + (ACC_WIDTH'(term_a) <<< SHIFT);
   assign acc_b_in = acc_b_prev + (ACC_WIDTH'(term_b) <<< SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         t_ff     <= t_in;
         acc_a_ff <= acc_a_in;
         acc_b_ff <= acc_b_in;
      end
   end

   assign valid_out = valid_ff;
   assign a_out     = a_ff;
   assign b_out     = b_ff;
   assign t_out     = t_ff;
   assign acc_a_out = acc_a_ff;
   assign acc_b_out = acc_b_ff;

endmodule

### design/vpr_coef.sv
`timescale 1ns / 1ps

// Angle reduction and sine/cosine lookup. Stage one reduces the angle to
// 0..359 degrees; stage two folds it into the quarter-wave table.
module vpr_coef (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic signed [vpr_pkg::ANGLE_W-1:0]   angle,
   output logic signed [vpr_pkg::COEF_W-1:0]    sine_coef,
   output logic signed [vpr_pkg::COEF_W-1:0]    cosine_coef,
   output logic                                 busy
);
   import vpr_pkg::*;

   logic [SUM_W-1:0]            red_sum;
   logic [DEG_W-1:0]            deg_in;
   logic [DEG_W-1:0]            deg_ff;
   logic                        load_ff;
   logic [IDX_W-1:0]            sin_idx, cos_idx;
   logic                        sin_neg, cos_neg;
   logic signed [COEF_W-1:0]    sin_mag, cos_mag;
   logic signed [COEF_W-1:0]    sine_coef_in, cosine_coef_in;
   logic signed [COEF_W-1:0]    sine_coef_ff, cosine_coef_ff;

   // Floor modulo 360: shift into the non-negative range, then take off
   // 360 * 2^k where it fits, largest first.
   always_comb begin
      red_sum = SUM_W'($signed({angle[ANGLE_W-1], angle}) + $signed(SUM_W'(DEG_OFFSET)));
      for (int k = REDUCE_STEPS - 1; k >= 0; k--) begin
         if (red_sum >= SUM_W'(DEG_TURN << k)) begin
            red_sum = red_sum - SUM_W'(DEG_TURN << k);
         end
      end
      deg_in = red_sum[DEG_W-1:0];
   end

   // Quadrant fold
   always_comb begin
      if (deg_ff <= DEG_W'(DEG_QUARTER)) begin
         sin_idx = IDX_W'(deg_ff);
         cos_idx = IDX_W'(DEG_W'(DEG_QUARTER) - deg_ff);
         sin_neg = 1'b0;
         cos_neg = 1'b0;
      end else if (deg_ff <= DEG_W'(DEG_HALF)) begin
         sin_idx = IDX_W'(DEG_W'(DEG_HALF) - deg_ff);
         cos_idx = IDX_W'(deg_ff - DEG_W'(DEG_QUARTER));
         sin_neg = 1'b0;
         cos_neg = 1'b1;
      end else if (deg_ff <= DEG_W'(DEG_THREEQ)) begin
         sin_idx = IDX_W'(deg_ff - DEG_W'(DEG_HALF));
         cos_idx = IDX_W'(DEG_W'(DEG_THREEQ) - deg_ff);
         sin_neg = 1'b1;
         cos_neg = 1'b1;
      end else begin
         sin_idx = IDX_W'(DEG_W'(DEG_TURN) - deg_ff);
         cos_idx = IDX_W'(deg_ff - DEG_W'(DEG_THREEQ));
         sin_neg = 1'b1;
         cos_neg = 1'b0;
      end
      sin_mag        = $signed({1'b0, QUARTER_SINE[sin_idx]});
      cos_mag        = $signed({1'b0, QUARTER_SINE[cos_idx]});
      sine_coef_in   = sin_neg ? -sin_mag : sin_mag;
      cosine_coef_in = cos_neg ? -cos_mag : cos_mag;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         deg_ff <= deg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff        <= 1'b0;
         sine_coef_ff   <= '0;
         cosine_coef_ff <= COEF_ONE;
      end else begin
         load_ff <= load;
         if (load_ff) begin
            sine_coef_ff   <= sine_coef_in;
            cosine_coef_ff <= cosine_coef_in;
         end
      end
   end

   assign sine_coef   = sine_coef_ff;
   assign cosine_coef = cosine_coef_ff;
   assign busy        = load_ff;

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      load |=> busy)
      else $error("coefficient reload not flagged busy");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      (sine_coef_ff <= COEF_ONE) && (sine_coef_ff >= -COEF_ONE) &&
      (cosine_coef_ff <= COEF_ONE) && (cosine_coef_ff >= -COEF_ONE))
      else $error("coefficient outside unit range");

endmodule

### design/vertex_plane_rotation_core.sv
`timescale 1ns / 1ps

// Plane rotation of Q-format vertices. Each vertex (x, y, z) on the req stream
// is rotated within the plane chosen by plane_select (XY, YZ or ZX; code 3 acts
// as ZX) by angle_degrees, a whole-degree angle taken modulo 360; the axis outside
// the plane passes unchanged. For plane (a, b): a' = a*cos - b*sin and
// b' = b*cos + a*sin, exact products, floor shift right by 16, saturated to the
// coordinate width. Sine and cosine come from a 91-entry quarter-wave table with
// 16 fraction bits. One vertex is accepted every cycle unless rsp stalls or a CSR
// write or reload is pending; it passes two multiply cells and one saturate/output
// register. The two cells each take a 9-bit slice of the coefficients and hand
// their partial sums to the next cell. Writing angle_degrees reloads the
// coefficients through a two-stage lookup; req_tready stays low in the write
// cycle and the cycle after. Write the configuration only while no vertex is in
// flight. csr_ready is always high; writes to unknown indices are dropped.
module vertex_plane_rotation_core #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata: x_in, y_in, z_in (COORD_WIDTH bits each), zero pad to bytes
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   // rsp_tdata: x_out, y_out, z_out (COORD_WIDTH bits each), zero pad to bytes
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [vpr_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [vpr_pkg::CSR_DATA_W-1:0]          csr_data
);
   import vpr_pkg::*;

   localparam int TDATA_W = ((3*COORD_WIDTH+7)/8)*8;
   localparam int ACC_W   = COORD_WIDTH + COEF_W + 1;
   localparam int SH_W    = ACC_W - COEF_FRAC;

   // Floor shift by the coefficient scale and clamp to the coordinate range
   function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [SH_W-1:0] sh;
      logic                   ovf;
      sh  = SH_W'(acc >>> COEF_FRAC);
      ovf = !((&sh[SH_W-1:COORD_WIDTH-1]) || !(|sh[SH_W-1:COORD_WIDTH-1]));
      if (ovf) begin
         clamp_coord = {sh[SH_W-1], {(COORD_WIDTH-1){~sh[SH_W-1]}}};
      end else begin
         clamp_coord = sh[COORD_WIDTH-1:0];
      end
   endfunction

   // Control
   logic                           advance;
   logic                           req_accept;
   logic                           angle_load;
   logic                           coef_busy;
   logic [PLANE_W-1:0]             plane_select_ff;
   logic signed [COEF_W-1:0]       sine_coef, cosine_coef;

   // Input fields
   logic signed [COORD_WIDTH-1:0]  x_in, y_in, z_in;

   // Chain links: index k feeds cell k
   logic                           valid_c [NCELL];
   logic signed [COORD_WIDTH-1:0]  a_c     [NCELL];
   logic signed [COORD_WIDTH-1:0]  b_c     [NCELL];
   logic signed [COORD_WIDTH-1:0]  t_c     [NCELL];
   logic signed [ACC_W-1:0]        acc_a_c [NCELL];
   logic signed [ACC_W-1:0]        acc_b_c [NCELL];

   // Last cell outputs
   logic                           last_valid;
   logic signed [COORD_WIDTH-1:0]  last_t;
   logic signed [ACC_W-1:0]        last_acc_a, last_acc_b;

   // Output register
   logic signed [COORD_WIDTH-1:0]  a_rot, b_rot;
   logic signed [COORD_WIDTH-1:0]  x_out_in, y_out_in, z_out_in;
   logic signed [COORD_WIDTH-1:0]  x_out_ff, y_out_ff, z_out_ff;
   logic                           rsp_tvalid_ff;

   // Advance the whole chain unless a finished result is held at the output
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance && !csr_valid && !coef_busy;
   assign req_accept = req_tvalid && req_tready;

   // Configuration
   assign csr_ready  = 1'b1;
   assign angle_load = csr_valid && (csr_index == CSR_ANGLE_DEGREES);

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_select_ff <= PLANE_XY;
      end else if (csr_valid && (csr_index == CSR_PLANE_SELECT)) begin
         plane_select_ff <= csr_data[PLANE_W-1:0];
      end
   end

   vpr_coef u_coef (
      .clock       (clock),
      .reset       (reset),
      .load        (angle_load),
      .angle       ($signed(csr_data[ANGLE_W-1:0])),
      .sine_coef   (sine_coef),
      .cosine_coef (cosine_coef),
      .busy        (coef_busy)
   );

   // Unpack the vertex and pick the rotation pair
   assign x_in = $signed(req_tdata[COORD_WIDTH-1:0]);
   assign y_in = $signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
   assign z_in = $signed(req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]);

   always_comb begin
      valid_c[0] = req_accept;
      acc_a_c[0] = '0;
      acc_b_c[0] = '0;
      case (plane_select_ff)
         PLANE_XY: begin
            a_c[0] = x_in;
            b_c[0] = y_in;
            t_c[0] = z_in;
         end
         PLANE_YZ: begin
            a_c[0] = y_in;
            b_c[0] = z_in;
            t_c[0] = x_in;
         end
         default: begin
            a_c[0] = z_in;
            b_c[0] = x_in;
            t_c[0] = y_in;
         end
      endcase
   end

   // Multiply chain, low coefficient slice first
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      if (k < NCELL - 1) begin : g_mid
         vpr_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .ACC_WIDTH   (ACC_W),
            .SLICE_POS   (k)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .valid_in   (valid_c[k]),
            .a_in       (a_c[k]),
            .b_in       (b_c[k]),
            .t_in       (t_c[k]),
            .acc_a_prev (acc_a_c[k]),
            .acc_b_prev (acc_b_c[k]),
            .cos_slice  (cosine_coef[k*SLICE_W +: SLICE_W]),
            .sin_slice  (sine_coef[k*SLICE_W +: SLICE_W]),
            .valid_out  (valid_c[k+1]),
            .a_out      (a_c[k+1]),
            .b_out      (b_c[k+1]),
            .t_out      (t_c[k+1]),
            .acc_a_out  (acc_a_c[k+1]),
            .acc_b_out  (acc_b_c[k+1])
         );
      end else begin : g_last
         vpr_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .ACC_WIDTH   (ACC_W),
            .SLICE_POS   (k)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .valid_in   (valid_c[k]),
            .a_in       (a_c[k]),
            .b_in       (b_c[k]),
            .t_in       (t_c[k]),
            .acc_a_prev (acc_a_c[k]),
            .acc_b_prev (acc_b_c[k]),
            .cos_slice  (cosine_coef[k*SLICE_W +: SLICE_W]),
            .sin_slice  (sine_coef[k*SLICE_W +: SLICE_W]),
            .valid_out  (last_valid),
            .a_out      (),
            .b_out      (),
            .t_out      (last_t),
            .acc_a_out  (last_acc_a),
            .acc_b_out  (last_acc_b)
         );
      end
   end

   // Scale, clamp and put the pair back on its axes
   always_comb begin
      a_rot = clamp_coord(last_acc_a);
      b_rot = clamp_coord(last_acc_b);
      case (plane_select_ff)
         PLANE_XY: begin
            x_out_in = a_rot;
            y_out_in = b_rot;
            z_out_in = last_t;
         end
         PLANE_YZ: begin
            x_out_in = last_t;
            y_out_in = a_rot;
            z_out_in = b_rot;
         end
         default: begin
            x_out_in = b_rot;
            y_out_in = last_t;
            z_out_in = a_rot;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_out_ff <= x_out_in;
         y_out_ff <= y_out_in;
         z_out_ff <= z_out_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = TDATA_W'({z_out_ff, y_out_ff, x_out_ff});

   a_rsp_from_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(last_valid))
      else $error("result raised without a finished transaction in the chain");

   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |=> $stable(last_valid) && $stable(last_acc_a))
      else $error("chain moved while the output was stalled");

   a_no_accept_on_reload: assert property (@(posedge clock) disable iff (reset)
      angle_load |=> !req_accept)
      else $error("transaction accepted during coefficient reload");

endmodule
